@@ src/plxy_pkg.sv @@
package plxy_pkg;

   localparam int TEMP_W = 15;
   localparam int OUT_W = 16;
   localparam int ACC_W = 36;
   localparam int VAR_W = 32;
   localparam int PROD_W = ACC_W + VAR_W;
   localparam int QUO_W = 31;
   localparam int Q_FRAC = 30;

   localparam logic [TEMP_W-1:0] T_MIN = 15'd1000;
   localparam logic [TEMP_W-1:0] T_SPLIT_LOW = 15'd2222;
   localparam logic [TEMP_W-1:0] T_SPLIT_MID = 15'd4000;
   localparam logic [TEMP_W-1:0] T_MAX = 15'd25000;

   // The reciprocal is 1000 * 2^30 / T. Its low 31 dividend bits are zero,
   // so the first partial remainder is 1000 / 2.
   localparam int RECIP_SCALE = 1000;
   localparam logic [TEMP_W-1:0] REM_INIT = TEMP_W'(RECIP_SCALE / 2);

   localparam logic [OUT_W-1:0] OUT_MAX = '1;

   localparam logic [1:0] Y_SET_A = 2'd0;
   localparam logic [1:0] Y_SET_B = 2'd1;
   localparam logic [1:0] Y_SET_C = 2'd2;

   localparam logic [2:0] SET_X_LOW = 3'd0;
   localparam logic [2:0] SET_X_HIGH = 3'd1;
   localparam logic [2:0] SET_Y_A = 3'd2;

   localparam longint Q30_ONE = 64'sd1073741824;
   localparam longint E9 = 64'sd1000000000;
   localparam longint E9_HALF = 64'sd500000000;

   function automatic logic signed [ACC_W-1:0] q30(input longint n, input logic neg);
      longint m;
      m = (n * Q30_ONE + E9_HALF) / E9;
      if (neg) begin
         m = -m;
      end
      return ACC_W'(m);
   endfunction

   localparam logic signed [ACC_W-1:0] COEF_TABLE [5][4] = '{
      '{q30(64'sd266123900, 1'b1), q30(64'sd234358000, 1'b1),
        q30(64'sd877695600, 1'b0), q30(64'sd179910000, 1'b0)},
      '{q30(64'sd3025846900, 1'b1), q30(64'sd2107037900, 1'b0),
        q30(64'sd222634700, 1'b0), q30(64'sd240390000, 1'b0)},
      '{q30(64'sd1106381400, 1'b1), q30(64'sd1348110200, 1'b1),
        q30(64'sd2185558320, 1'b0), q30(64'sd202196830, 1'b1)},
      '{q30(64'sd954947600, 1'b1), q30(64'sd1374185930, 1'b1),
        q30(64'sd2091370150, 1'b0), q30(64'sd167488670, 1'b1)},
      '{q30(64'sd3081758000, 1'b0), q30(64'sd5873386700, 1'b1),
        q30(64'sd3751129970, 1'b0), q30(64'sd370014830, 1'b1)}
   };

   typedef struct packed {
      logic valid;
      logic hot;
      logic xhi;
      logic [1:0] yset;
      logic [TEMP_W-1:0] temp;
      logic [TEMP_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_type;

   typedef struct packed {
      logic valid;
      logic hot;
      logic xhi;
      logic [1:0] yset;
      logic signed [VAR_W-1:0] v;
      logic signed [ACC_W-1:0] acc;
      logic signed [PROD_W-1:0] prod;
      logic signed [ACC_W-1:0] x;
   } mac_type;

   typedef struct packed {
      logic valid;
      logic [OUT_W-1:0] chroma_x;
      logic [OUT_W-1:0] chroma_y;
      logic in_range;
   } out_type;

endpackage

@@ src/planckian_locus_xy.sv @@
// Maps a color temperature in kelvin to the CIE 1931 (x, y) point on the
// Planckian locus with the piecewise cubic approximation, giving x and y as
// unsigned fixed point with FRAC_BITS fraction bits. Temperatures below
// 1000 K are evaluated as 1000 K, and temperatures above 25000 K return zero
// coordinates with in_range low. The block takes one transaction per clock
// cycle while no stall holds it. Each item passes through 46 registers: the
// input register, 31 stages of a one-bit-per-stage reciprocal divider, one
// coefficient setup stage, six Horner steps of a multiply stage and an add
// stage each, and the rounding output register. A stall on the result side
// holds the whole pipeline.
module planckian_locus_xy #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [plxy_pkg::TEMP_W-1:0] req_temperature_kelvin,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [plxy_pkg::OUT_W-1:0] rsp_chroma_x,
   output logic [plxy_pkg::OUT_W-1:0] rsp_chroma_y,
   output logic rsp_in_range
);

   localparam int DIV_STAGES = plxy_pkg::QUO_W;
   localparam int MAC_STAGES = 12;
   localparam int ROUND_SHIFT = plxy_pkg::Q_FRAC - FRAC_BITS;
   localparam logic [plxy_pkg::ACC_W:0] ROUND_HALF = (plxy_pkg::ACC_W + 1)'(1) << (ROUND_SHIFT - 1);

   plxy_pkg::div_type div_ff [DIV_STAGES+1];
   plxy_pkg::div_type div_in [DIV_STAGES+1];
   plxy_pkg::mac_type mac_ff [MAC_STAGES+1];
   plxy_pkg::mac_type mac_in [MAC_STAGES+1];
   plxy_pkg::out_type out_ff;
   plxy_pkg::out_type out_in;
   logic advance;

   function automatic logic [plxy_pkg::OUT_W-1:0] to_output(input logic signed [plxy_pkg::ACC_W-1:0] v);
      logic [plxy_pkg::ACC_W:0] r;
      logic [plxy_pkg::OUT_W-1:0] o;
      if (v < 0) begin
         o = '0;
      end else begin
         r = ({1'b0, v} + ROUND_HALF) >> ROUND_SHIFT;
         if (r > (plxy_pkg::ACC_W + 1)'(plxy_pkg::OUT_MAX)) begin
            o = plxy_pkg::OUT_MAX;
         end else begin
            o = r[plxy_pkg::OUT_W-1:0];
         end
      end
      return o;
   endfunction

   assign advance = !out_ff.valid || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      logic [plxy_pkg::TEMP_W-1:0] tc;
      tc = (req_temperature_kelvin < plxy_pkg::T_MIN) ? plxy_pkg::T_MIN : req_temperature_kelvin;
      div_in[0].valid = req_valid;
      div_in[0].hot = req_temperature_kelvin > plxy_pkg::T_MAX;
      div_in[0].xhi = tc > plxy_pkg::T_SPLIT_MID;
      if (tc <= plxy_pkg::T_SPLIT_LOW) begin
         div_in[0].yset = plxy_pkg::Y_SET_A;
      end else if (tc <= plxy_pkg::T_SPLIT_MID) begin
         div_in[0].yset = plxy_pkg::Y_SET_B;
      end else begin
         div_in[0].yset = plxy_pkg::Y_SET_C;
      end
      div_in[0].temp = tc;
      div_in[0].rem = plxy_pkg::REM_INIT;
      div_in[0].quo = '0;
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      always_comb begin
         logic [plxy_pkg::TEMP_W:0] r2;
         logic take;
         r2 = {div_ff[k].rem, 1'b0};
         take = r2 >= {1'b0, div_ff[k].temp};
         div_in[k+1] = div_ff[k];
         div_in[k+1].rem = take ? plxy_pkg::TEMP_W'(r2 - {1'b0, div_ff[k].temp})
                                : plxy_pkg::TEMP_W'(r2);
         div_in[k+1].quo = {div_ff[k].quo[plxy_pkg::QUO_W-2:0], take};
      end
   end

   always_comb begin
      logic [2:0] xs;
      xs = div_ff[DIV_STAGES].xhi ? plxy_pkg::SET_X_HIGH : plxy_pkg::SET_X_LOW;
      mac_in[0].valid = div_ff[DIV_STAGES].valid;
      mac_in[0].hot = div_ff[DIV_STAGES].hot;
      mac_in[0].xhi = div_ff[DIV_STAGES].xhi;
      mac_in[0].yset = div_ff[DIV_STAGES].yset;
      mac_in[0].v = plxy_pkg::VAR_W'(div_ff[DIV_STAGES].quo);
      mac_in[0].acc = plxy_pkg::COEF_TABLE[xs][0];
      mac_in[0].prod = '0;
      mac_in[0].x = '0;
   end

   for (genvar m = 0; m < MAC_STAGES; m++) begin : g_mac
      localparam int STEP = m / 2;
      always_comb begin
         logic [2:0] cs;
         logic [2:0] ys;
         logic signed [plxy_pkg::ACC_W-1:0] sum;
         ys = plxy_pkg::SET_Y_A + 3'(mac_ff[m].yset);
         if (STEP < 3) begin
            cs = mac_ff[m].xhi ? plxy_pkg::SET_X_HIGH : plxy_pkg::SET_X_LOW;
         end else begin
            cs = ys;
         end
         mac_in[m+1] = mac_ff[m];
         sum = plxy_pkg::ACC_W'(mac_ff[m].prod >>> plxy_pkg::Q_FRAC)
             + plxy_pkg::COEF_TABLE[cs][(STEP % 3) + 1];
         if ((m % 2) == 0) begin
            mac_in[m+1].prod = plxy_pkg::PROD_W'(mac_ff[m].acc) * plxy_pkg::PROD_W'(mac_ff[m].v);
         end else if (STEP == 2) begin
            mac_in[m+1].x = sum;
            mac_in[m+1].v = plxy_pkg::VAR_W'(sum);
            mac_in[m+1].acc = plxy_pkg::COEF_TABLE[ys][0];
         end else begin
            mac_in[m+1].acc = sum;
         end
      end
   end

   always_comb begin
      out_in.valid = mac_ff[MAC_STAGES].valid;
      out_in.in_range = !mac_ff[MAC_STAGES].hot;
      out_in.chroma_x = mac_ff[MAC_STAGES].hot ? '0 : to_output(mac_ff[MAC_STAGES].x);
      out_in.chroma_y = mac_ff[MAC_STAGES].hot ? '0 : to_output(mac_ff[MAC_STAGES].acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_STAGES; i++) begin
            div_ff[i].valid <= 1'b0;
         end
         for (int i = 0; i <= MAC_STAGES; i++) begin
            mac_ff[i].valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i <= DIV_STAGES; i++) begin
            div_ff[i] <= div_in[i];
         end
         for (int i = 0; i <= MAC_STAGES; i++) begin
            mac_ff[i] <= mac_in[i];
         end
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_ff.valid;
   assign rsp_chroma_x = out_ff.chroma_x;
   assign rsp_chroma_y = out_ff.chroma_y;
   assign rsp_in_range = out_ff.in_range;

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_chroma_x == '0 && rsp_chroma_y == '0)
      else $error("out-of-range result carries nonzero coordinates");

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready disagrees with output register state");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      div_ff[DIV_STAGES].valid |-> div_ff[DIV_STAGES].rem < div_ff[DIV_STAGES].temp)
      else $error("divider remainder not below divisor");

   a_recip_range: assert property (@(posedge clock) disable iff (reset)
      div_ff[DIV_STAGES].valid && !div_ff[DIV_STAGES].hot
      |-> div_ff[DIV_STAGES].quo[plxy_pkg::QUO_W-1:25] != '0)
      else $error("reciprocal below its lowest possible value");

endmodule

@@ dv/planckian_locus_xy_checker.sv @@
module planckian_locus_xy_checker #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic [plxy_pkg::TEMP_W-1:0] req_temperature_kelvin,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic [plxy_pkg::OUT_W-1:0] rsp_chroma_x,
   input  logic [plxy_pkg::OUT_W-1:0] rsp_chroma_y,
   input  logic rsp_in_range,
   output int error_count,
   output int pending_count,
   output int result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [plxy_pkg::OUT_W-1:0] chroma_x;
      logic [plxy_pkg::OUT_W-1:0] chroma_y;
      logic in_range;
   } locus_point_type;

   locus_point_type point_queue[$];

   function automatic longint coef(input longint milli_nano);
      longint m;
      longint a;
      a = (milli_nano < 0) ? -milli_nano : milli_nano;
      m = (a * 64'sd1073741824 + 64'sd500000000) / 64'sd1000000000;
      return (milli_nano < 0) ? -m : m;
   endfunction

   function automatic longint fix_mul(input longint a, input longint b);
      longint p;
      p = a * b;
      if (p >= 0) begin
         return p >>> 30;
      end
      return -((-p + 64'sd1073741823) >>> 30);
   endfunction

   function automatic longint horner(input longint c0, input longint c1, input longint c2,
                                     input longint c3, input longint v);
      longint acc;
      acc = c0;
      acc = fix_mul(acc, v) + c1;
      acc = fix_mul(acc, v) + c2;
      acc = fix_mul(acc, v) + c3;
      return acc;
   endfunction

   function automatic logic [15:0] round_out(input longint v);
      longint r;
      if (v < 0) begin
         return 16'd0;
      end
      r = (v + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      if (r > 65535) begin
         return 16'hFFFF;
      end
      return r[15:0];
   endfunction

   function automatic locus_point_type locus_point(input logic [14:0] temp_in);
      locus_point_type p;
      longint t;
      longint s;
      longint x;
      longint y;
      t = temp_in;
      if (t > 25000) begin
         p = '0;
         return p;
      end
      if (t < 1000) begin
         t = 1000;
      end
      s = (64'sd1000 <<< 30) / t;
      if (t <= 4000) begin
         x = horner(coef(-266123900), coef(-234358000), coef(877695600), coef(179910000), s);
      end else begin
         x = horner(coef(-64'sd3025846900), coef(64'sd2107037900), coef(222634700),
                    coef(240390000), s);
      end
      if (t <= 2222) begin
         y = horner(coef(-1106381400), coef(-1348110200), coef(64'sd2185558320),
                    coef(-202196830), x);
      end else if (t <= 4000) begin
         y = horner(coef(-954947600), coef(-1374185930), coef(64'sd2091370150),
                    coef(-167488670), x);
      end else begin
         y = horner(coef(64'sd3081758000), coef(-64'sd5873386700), coef(64'sd3751129970),
                    coef(-370014830), x);
      end
      p.chroma_x = round_out(x);
      p.chroma_y = round_out(y);
      p.in_range = 1'b1;
      return p;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   assign pending_count = point_queue.size();

   always @(posedge clock) begin
      locus_point_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            point_queue.insert(point_queue.size(), locus_point(req_temperature_kelvin));
         end
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (point_queue.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               want = point_queue.pop_front();
               if (rsp_chroma_x !== want.chroma_x) begin
                  report_mismatch("chroma_x", rsp_chroma_x, want.chroma_x);
               end
               if (rsp_chroma_y !== want.chroma_y) begin
                  report_mismatch("chroma_y", rsp_chroma_y, want.chroma_y);
               end
               if (rsp_in_range !== want.in_range) begin
                  report_mismatch("in_range", rsp_in_range, want.in_range);
               end
            end
         end
      end
   end
endmodule

@@ dv/planckian_locus_xy_test.sv @@
module planckian_locus_xy_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [plxy_pkg::TEMP_W-1:0] req_temperature_kelvin = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [plxy_pkg::OUT_W-1:0] rsp_chroma_x;
   logic [plxy_pkg::OUT_W-1:0] rsp_chroma_y;
   logic rsp_in_range;
   int error_count;
   int pending_count;
   int result_count;
   int idle_cycles = 0;
   int sent_count = 0;
   bit hold_off = 1'b0;

   always #5 clock = ~clock;

   planckian_locus_xy u_dut (.*);

   planckian_locus_xy_checker u_checker (.*);

   function automatic logic [14:0] random_temperature();
      case ($urandom_range(0, 9))
         0: return 15'($urandom_range(0, 32767));
         1: return 15'($urandom_range(0, 1000));
         2: return 15'($urandom_range(2200, 2244));
         3: return 15'($urandom_range(3980, 4020));
         4: return 15'($urandom_range(24980, 25020));
         5: return 15'($urandom_range(25001, 32767));
         default: return 15'($urandom_range(1000, 25000));
      endcase
   endfunction

   task automatic send_temperature(input logic [14:0] temp_in);
      req_valid <= 1'b1;
      req_temperature_kelvin <= temp_in;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sent_count++;
   endtask

   task automatic send_gap();
      req_valid <= 1'b0;
      req_temperature_kelvin <= 15'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   initial begin
      logic [14:0] directed[$];
      int burst;
      directed = '{15'd0, 15'd1, 15'd999, 15'd1000, 15'd1001, 15'd1667, 15'd2221, 15'd2222,
                   15'd2223, 15'd3999, 15'd4000, 15'd4001, 15'd6500, 15'd24999, 15'd25000,
                   15'd25001, 15'd32767, 15'h5555, 15'h2AAA, 15'd16384};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         send_temperature(directed[i]);
      end
      while (sent_count < 630) begin
         burst = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         repeat (burst) send_temperature(random_temperature());
         send_gap();
      end
      req_valid <= 1'b0;
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (60) @(posedge clock);
      $display("%0d temperatures sent, %0d results checked, across all curve segments,",
               sent_count, result_count);
      $display("the clamp at 1000 K, out-of-range inputs and output backpressure.");
      if (error_count == 0) begin
         $display("planckian_locus_xy_test: done, clean");
      end else begin
         $display("planckian_locus_xy_test: done, errors");
      end
      $finish;
   end

   initial begin
      @(posedge clock);
      while (sent_count < 150) begin
         @(posedge clock);
      end
      hold_off <= 1'b1;
      repeat (200) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      if (hold_off) begin
         rsp_ready <= 1'b0;
      end else if (sent_count > 400 && sent_count < 470) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("planckian_locus_xy_test: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end
endmodule

@@ planckian_locus_xy.f @@
src/plxy_pkg.sv
src/planckian_locus_xy.sv
dv/planckian_locus_xy_checker.sv
dv/planckian_locus_xy_test.sv
